@@ hw/rtl/esd_pkg.sv @@
// types, constants and the alphabet lookup of the encoded symbol decoder
package esd_pkg;

   localparam int unsigned SYM_BITS  = 6;
   localparam int unsigned TAIL_BITS = 4;
   localparam int unsigned NID_BITS  = 64;
   localparam int unsigned POS_BITS  = 5;

   localparam logic [POS_BITS-1:0] NAME_LEN  = 5'd15;
   localparam logic [POS_BITS-1:0] TAIL_POS  = 5'd10;
   localparam logic [POS_BITS-1:0] SEP_POS_A = 5'd11;
   localparam logic [POS_BITS-1:0] LIB_POS   = 5'd12;
   localparam logic [POS_BITS-1:0] SEP_POS_B = 5'd13;
   localparam logic [POS_BITS-1:0] MOD_POS   = 5'd14;
   localparam logic [POS_BITS-1:0] POS_SAT   = 5'd16;

   localparam logic [7:0] SEP_CHAR   = 8'h23;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] MINUS_CHAR = 8'h2D;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } esd_req_type;

   typedef struct packed {
      logic                encoded;
      logic                chars_ok;
      logic [NID_BITS-1:0] nid;
      logic [SYM_BITS-1:0] lib_id;
      logic [SYM_BITS-1:0] module_id;
   } esd_rsp_type;

   typedef struct packed {
      logic                ok;
      logic [SYM_BITS-1:0] idx;
   } sym_type;

   // A-Z a-z 0-9 + - to 0..63, ok low for anything else
   function automatic sym_type sym_lookup(input logic [7:0] c);
      sym_type    s;
      logic [7:0] d;
      s = '{ok: 1'b1, idx: '0};
      d = '0;
      case (c) inside
         [8'h41:8'h5A]: d = c - 8'h41;
         [8'h61:8'h7A]: d = c - 8'h61 + 8'd26;
         [8'h30:8'h39]: d = c - 8'h30 + 8'd52;
         PLUS_CHAR:     d = 8'd62;
         MINUS_CHAR:    d = 8'd63;
         default:       s.ok = 1'b0;
      endcase
      s.idx = d[SYM_BITS-1:0];
      return s;
   endfunction

endpackage

@@ hw/rtl/esd_if.sv @@
// valid/ready channels for characters in and decoded names out
interface esd_req_if import esd_pkg::*; ();
   logic        valid;
   logic        ready;
   esd_req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface esd_rsp_if import esd_pkg::*; ();
   logic        valid;
   logic        ready;
   esd_rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/encoded_symbol_decoder_unit.sv @@
// encoded symbol name decoder: character stream in, one decoded word per name out
//
//   channel   dir  word                                      per
//   req_chan  in   ch[7:0], last                             character
//   rsp_chan  out  encoded, chars_ok, nid[63:0], lib_id,     name
//                  module_id
//
// one character is taken per cycle unless a word waits on a stalled output;
// the decoder state updates in the same edge, and the decoded word is loaded
// into the output register from the last character, valid in the cycle after it
// reset clears the decoder state and the output valid flag
// a stalled output holds the word; characters are taken while the word leaves
module encoded_symbol_decoder_unit import esd_pkg::*; (
   input logic      clock,
   input logic      reset,
   esd_req_if.sink  req_chan,
   esd_rsp_if.source rsp_chan
);

   logic [POS_BITS-1:0] position_ff,      position_in;
   logic [NID_BITS-1:0] nid_accum_ff,     nid_accum_in;
   logic                nid_stopped_ff,   nid_stopped_in;
   logic [SYM_BITS-1:0] lib_accum_ff,     lib_accum_in;
   logic [SYM_BITS-1:0] module_accum_ff,  module_accum_in;
   logic                separators_ok_ff, separators_ok_in;
   logic                all_chars_ok_ff,  all_chars_ok_in;
   logic                rsp_valid_ff,     rsp_valid_in;
   esd_rsp_type         rsp_data_ff,      rsp_data_in;

   logic    take;
   logic    enc;
   sym_type sym;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign sym            = sym_lookup(req_chan.data.ch);

   always_comb begin
      position_in      = position_ff;
      nid_accum_in     = nid_accum_ff;
      nid_stopped_in   = nid_stopped_ff;
      lib_accum_in     = lib_accum_ff;
      module_accum_in  = module_accum_ff;
      separators_ok_in = separators_ok_ff;
      all_chars_ok_in  = all_chars_ok_ff;

      if (position_ff <= TAIL_POS) begin
         if (!nid_stopped_ff) begin
            if (!sym.ok) begin
               nid_stopped_in  = 1'b1;
               all_chars_ok_in = 1'b0;
            end else if (position_ff < TAIL_POS) begin
               nid_accum_in = {nid_accum_ff[NID_BITS-SYM_BITS-1:0], sym.idx};
            end else begin
               // last identifier character gives only its top bits
               nid_accum_in = {nid_accum_ff[NID_BITS-TAIL_BITS-1:0],
                               sym.idx[SYM_BITS-1 -: TAIL_BITS]};
            end
         end
      end else if (position_ff == SEP_POS_A || position_ff == SEP_POS_B) begin
         if (req_chan.data.ch != SEP_CHAR) separators_ok_in = 1'b0;
      end else if (position_ff == LIB_POS) begin
         if (sym.ok) lib_accum_in = sym.idx; else all_chars_ok_in = 1'b0;
      end else if (position_ff == MOD_POS) begin
         if (sym.ok) module_accum_in = sym.idx; else all_chars_ok_in = 1'b0;
      end

      if (position_ff < POS_SAT) position_in = position_ff + 5'd1;

      enc = (position_in == NAME_LEN) && separators_ok_in;
      rsp_data_in.encoded   = enc;
      rsp_data_in.chars_ok  = all_chars_ok_in;
      rsp_data_in.nid       = enc ? nid_accum_in : '0;
      rsp_data_in.lib_id    = enc ? lib_accum_in : '0;
      rsp_data_in.module_id = enc ? module_accum_in : '0;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (take && req_chan.data.last) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff      <= '0;
         nid_accum_ff     <= '0;
         nid_stopped_ff   <= 1'b0;
         lib_accum_ff     <= '0;
         module_accum_ff  <= '0;
         separators_ok_ff <= 1'b1;
         all_chars_ok_ff  <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            if (req_chan.data.last) begin
               // name complete: start over for the next one
               position_ff      <= '0;
               nid_accum_ff     <= '0;
               nid_stopped_ff   <= 1'b0;
               lib_accum_ff     <= '0;
               module_accum_ff  <= '0;
               separators_ok_ff <= 1'b1;
               all_chars_ok_ff  <= 1'b1;
            end else begin
               position_ff      <= position_in;
               nid_accum_ff     <= nid_accum_in;
               nid_stopped_ff   <= nid_stopped_in;
               lib_accum_ff     <= lib_accum_in;
               module_accum_ff  <= module_accum_in;
               separators_ok_ff <= separators_ok_in;
               all_chars_ok_ff  <= all_chars_ok_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_chan.data.last) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

`ifndef SYNTH
   a_word_needs_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(take && req_chan.data.last))
      else $error("output word without a last character");

   a_plain_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.encoded |->
         rsp_data_ff.nid == '0 && rsp_data_ff.lib_id == '0 &&
         rsp_data_ff.module_id == '0)
      else $error("ids not zero on a name that is not encoded");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_SAT)
      else $error("position counter past saturation");

   a_stop_clears_ok: assert property (@(posedge clock) disable iff (reset)
      nid_stopped_ff |-> !all_chars_ok_ff)
      else $error("identifier stopped but characters still reported ok");
`endif

endmodule

@@ tb/esd_tb_pkg.sv @@
`timescale 1ns / 100ps
// decode tracker: predicts the word for each name and checks the words the block sends
package esd_tb_pkg;
   import esd_pkg::*;

   typedef logic [7:0] name_type[$];

   localparam int unsigned REPORT_LIMIT = 10;

   class decode_tracker;
      logic [POS_BITS-1:0] pos;
      logic [NID_BITS-1:0] nid_acc;
      bit                  nid_halted;
      logic [SYM_BITS-1:0] lib_acc;
      logic [SYM_BITS-1:0] mod_acc;
      bit                  seps_ok;
      bit                  chars_ok;

      esd_rsp_type expected_words[$];

      int unsigned mismatches;
      int unsigned words_checked;
      int unsigned names_taken;
      int unsigned encoded_words;
      int unsigned bad_char_words;

      function new();
         mismatches     = 0;
         words_checked  = 0;
         names_taken    = 0;
         encoded_words  = 0;
         bad_char_words = 0;
         clear_name();
      endfunction

      function void clear_name();
         pos        = '0;
         nid_acc    = '0;
         nid_halted = 1'b0;
         lib_acc    = '0;
         mod_acc    = '0;
         seps_ok    = 1'b1;
         chars_ok   = 1'b1;
      endfunction

      // index 0..63, or 64 when the byte is outside the alphabet
      function logic [6:0] alpha_code(logic [7:0] c);
         if (c >= "A" && c <= "Z") return 7'(c - "A");
         if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
         if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
         if (c == "+") return 7'd62;
         if (c == "-") return 7'd63;
         return 7'd64;
      endfunction

      function void take_char(logic [7:0] c, logic last);
         logic [6:0]  code;
         bit          enc;
         esd_rsp_type w;
         code = alpha_code(c);
         if (pos <= TAIL_POS) begin
            // once an identifier character is bad the rest of the identifier is skipped
            if (!nid_halted) begin
               if (code[6]) begin
                  nid_halted = 1'b1;
                  chars_ok   = 1'b0;
               end else if (pos < TAIL_POS) begin
                  nid_acc = {nid_acc[NID_BITS-SYM_BITS-1:0], code[SYM_BITS-1:0]};
               end else begin
                  nid_acc = {nid_acc[NID_BITS-TAIL_BITS-1:0], code[SYM_BITS-1:2]};
               end
            end
         end else if (pos == SEP_POS_A || pos == SEP_POS_B) begin
            if (c != SEP_CHAR) seps_ok = 1'b0;
         end else if (pos == LIB_POS) begin
            if (!code[6]) lib_acc = code[SYM_BITS-1:0]; else chars_ok = 1'b0;
         end else if (pos == MOD_POS) begin
            if (!code[6]) mod_acc = code[SYM_BITS-1:0]; else chars_ok = 1'b0;
         end
         if (pos < POS_SAT) pos++;
         if (last) begin
            enc         = (pos == NAME_LEN) && seps_ok;
            w.encoded   = enc;
            w.chars_ok  = chars_ok;
            w.nid       = enc ? nid_acc : '0;
            w.lib_id    = enc ? lib_acc : '0;
            w.module_id = enc ? mod_acc : '0;
            expected_words = {expected_words, w};
            names_taken++;
            encoded_words  += enc;
            bad_char_words += !chars_ok;
            clear_name();
         end
      endfunction

      function string word_text(esd_rsp_type w);
         return $sformatf("encoded %b chars_ok %b nid %h lib %0d module %0d",
                          w.encoded, w.chars_ok, w.nid, w.lib_id, w.module_id);
      endfunction

      function void check_word(esd_rsp_type got);
         esd_rsp_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("word with none expected: %s", word_text(got));
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (got.encoded !== want.encoded || got.chars_ok !== want.chars_ok ||
             got.nid !== want.nid || got.lib_id !== want.lib_id ||
             got.module_id !== want.module_id) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("word %0d mismatch", words_checked);
               $display("   expected %s", word_text(want));
               $display("   actual   %s", word_text(got));
            end
         end
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// top of the encoded symbol decoder testbench: stimulus, handshakes and the verdict
module tb_top;
   import esd_pkg::*;
   import esd_tb_pkg::*;

   localparam int unsigned CHAR_TARGET  = 450;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam string ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-";

   logic          clock;
   logic          reset;
   int unsigned   cycle_count = 0;
   int unsigned   sender_idle_pct = 0;
   int unsigned   receiver_stall_pct = 0;
   int unsigned   chars_sent = 0;
   decode_tracker tracker;

   esd_req_if req_chan();
   esd_rsp_if rsp_chan();

   encoded_symbol_decoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // words are checked before the character of the same edge is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) tracker.check_word(rsp_chan.data);
         if (req_chan.valid && req_chan.ready)
            tracker.take_char(req_chan.data.ch, req_chan.data.last);
      end
   end

   function automatic logic [7:0] pick_symbol();
      return ALPHABET[$urandom_range(63)];
   endfunction

   function automatic name_type from_text(string s);
      name_type n;
      for (int i = 0; i < s.len(); i++) n = {n, s[i]};
      return n;
   endfunction

   function automatic name_type random_well_formed();
      name_type n;
      for (int i = 0; i < NAME_LEN; i++)
         n = {n, (i == SEP_POS_A || i == SEP_POS_B) ? SEP_CHAR : pick_symbol()};
      return n;
   endfunction

   function automatic name_type random_name();
      name_type    n;
      int unsigned r;
      int unsigned k;
      int unsigned len;
      r = $urandom_range(99);
      if (r < 85) begin
         n = random_well_formed();
         if (r >= 55 && r < 75) begin
            k = $urandom_range(3);
            n[$urandom_range(NAME_LEN - 1)] = (k == 0) ? SEP_CHAR :
                                              (k == 1) ? pick_symbol() :
                                              8'($urandom_range(255));
         end else if (r >= 75) begin
            if ($urandom_range(1) == 0) begin
               len = $urandom_range(1, NAME_LEN - 1);
               while (n.size() > len) void'(n.pop_back());
            end else begin
               repeat ($urandom_range(1, 6))
                  n = {n, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                          pick_symbol()};
            end
         end
      end else begin
         // noise: any bytes at lengths of 1 to 20
         repeat ($urandom_range(1, 20)) n = {n, 8'($urandom_range(255))};
      end
      return n;
   endfunction

   // called at a rising edge; returns at the edge where the character is taken
   task automatic send_char(logic [7:0] c, logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= '{ch: c, last: last};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_name(name_type n);
      foreach (n[i]) send_char(n[i], i == n.size() - 1);
   endtask

   task automatic send_directed();
      name_type n;
      send_name(from_text("AAAAAAAAAAA#A#A"));
      send_name(from_text("-----------#-#-"));
      send_name(from_text("Zz09+-AbYy8#+#9"));
      // byte zero inside the identifier
      n = from_text("ABCDEFGHIJK#L#M");
      n[2] = 8'h00;
      send_name(n);
      // separator char inside the identifier, library and module ids still decoded
      send_name(from_text("abcde#ghijk#l#m"));
      // bad char on the 4-bit tail position
      send_name(from_text("0123456789.#5#6"));
      // bad library and module chars
      n = from_text("QRSTUVWXYZa#!#b");
      n[14] = 8'hFF;
      send_name(n);
      send_name(from_text("ABCDEFGHIJKA+#-"));
      send_name(from_text("ABCDEFGHIJK#+$-"));
      // wrong lengths, including past saturation
      send_name(from_text("ABCDEFGHIJK#A#AAAAAA"));
      send_name(from_text("ABCDEFGHIJK#A#AB"));
      send_name(from_text("ABCDEFGHIJK#A#"));
      send_name(from_text("Q"));
   endtask

   initial begin
      int unsigned directed_chars;
      tracker            = new();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data      = '0;
      rsp_chan.ready     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_directed();
      directed_chars = chars_sent;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 53;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 53;
            end
            default: begin
               sender_idle_pct    = 27;
               receiver_stall_pct = 27;
            end
         endcase
         // random names fill up what the directed names leave of the target
         while (chars_sent < directed_chars +
                (phase + 1) * (CHAR_TARGET - directed_chars) / 4)
            send_name(random_name());
      end

      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d characters in %0d names sent, %0d decoded words checked",
               chars_sent, tracker.names_taken, tracker.words_checked);
      $display("%0d words encoded, %0d with a bad character, %0d mismatches",
               tracker.encoded_words, tracker.bad_char_words, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/esd_pkg.sv
hw/rtl/esd_if.sv
hw/rtl/encoded_symbol_decoder_unit.sv
tb/esd_tb_pkg.sv
tb/tb_top.sv
